// ===== rtl/core/rws_pkg.sv =====
package rws_pkg;

    // Cumulative sums of squared Q8.8 fitness, unsigned Q26.16
    localparam int SUM_W = 42;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Result index width
    localparam int IDX_W = 10;

    // Shared multiplier operand widths: a 42-bit total is split into two halves
    localparam int MUL_A_W = SUM_W / 2;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SELECT = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        first;
        logic [15:0] fitness;
        logic [15:0] random_fraction;
    } job_t;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_index;
        logic             empty_error;
    } pick_t;

endpackage

// ===== rtl/core/rws_mul.sv =====
module rws_mul (
    input  logic                       clk,
    input  logic [rws_pkg::MUL_A_W-1:0] a,
    input  logic [rws_pkg::MUL_B_W-1:0] b,
    output logic [rws_pkg::MUL_P_W-1:0] p
);
    import rws_pkg::*;

    logic [MUL_P_W-1:0] p_reg;
    logic [MUL_P_W-1:0] p_next;

    // unsigned product, registered
    assign p_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/roulette_wheel_parent_select.sv =====
// Roulette-wheel parent selection with squared fitness. A load item (cmd 0)
// squares its Q8.8 fitness, adds it to a saturating 42-bit running total and
// stores that total in the prefix table at the next free index; first=1
// starts a new population before the value is stored, and a load into a full
// table without first is dropped. A load gives no result.
// A select item (cmd 1) forms threshold = (total * random_fraction) >> 16 and
// returns the smallest index below count-1 whose prefix sum exceeds it, else
// count-1; on an empty table it returns index 0 with empty_error set. The
// threshold comes from one shared 21x16 multiplier used twice, and the index
// from a binary search of the prefix memory: each search step is one
// registered memory read plus one compare.
// job_stall is high while an item is in work or its result waits for the
// output register, which lets the next item in while a result still waits
// to be taken.
module roulette_wheel_parent_select #(
    parameter int POP_DEPTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_stall,
    input  rws_pkg::job_t job,
    output logic          pick_valid,
    input  logic          pick_stall,
    output rws_pkg::pick_t pick
);
    import rws_pkg::*;

    localparam int AW = (POP_DEPTH > 1) ? $clog2(POP_DEPTH) : 1;
    localparam int CW = $clog2(POP_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_ACC,
        ST_SL_MLO,
        ST_SL_MHI,
        ST_SL_THR,
        ST_SR_CHK,
        ST_SR_CMP
    } state_t;

    // Prefix table, undefined until written
    logic [SUM_W-1:0] prefix_mem [POP_DEPTH];

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [SUM_W-1:0]   total_reg;
    logic [15:0]        operand_reg;   // fitness on load, fraction on select
    logic [MUL_P_W-1:0] lo_prod_reg;
    logic [SUM_W-1:0]   thr_reg;
    logic [AW-1:0]      lo_reg;
    logic [AW-1:0]      hi_reg;
    logic [AW-1:0]      mid_reg;
    logic [SUM_W-1:0]   rd_data_reg;
    logic               pick_valid_reg;
    pick_t              pick_reg;
    logic               done_reg;      // result ready to leave
    pick_t              done_data_reg;

    logic               job_take;
    logic               pick_take;
    logic               out_free;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic [SUM_W:0]     acc_sum;
    logic [SUM_W-1:0]   acc_next;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      mid_next;
    logic [MUL_P_W+MUL_A_W-1:0] thr_full;
    logic [AW+IDX_W-1:0] idx_wide;

    assign job_stall = (state_reg != ST_IDLE) || done_reg;
    assign job_take  = job_valid && !job_stall;
    assign pick_take = pick_valid_reg && !pick_stall;
    assign out_free  = !pick_valid_reg || !pick_stall;

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_LD_MUL: begin
                mul_a = MUL_A_W'(operand_reg);
                mul_b = operand_reg;
            end
            ST_SL_MLO: begin
                mul_a = total_reg[MUL_A_W-1:0];
                mul_b = operand_reg;
            end
            ST_SL_MHI: begin
                mul_a = total_reg[SUM_W-1:MUL_A_W];
                mul_b = operand_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rws_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // saturating accumulate of fitness squared
    assign acc_sum  = {1'b0, total_reg} + (SUM_W + 1)'(mul_p[31:0]);
    assign acc_next = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
    assign mem_we   = (state_reg == ST_LD_ACC) && (count_reg < CW'(POP_DEPTH));
    assign wr_addr  = count_reg[AW-1:0];

    // threshold: (hi_prod << 21) + lo_prod, then drop 16 fraction bits
    assign thr_full = {mul_p, {MUL_A_W{1'b0}}} + (MUL_P_W + MUL_A_W)'(lo_prod_reg);

    assign mid_next = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_wide = {{IDX_W{1'b0}}, lo_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prefix_mem[wr_addr] <= acc_next;
        end
        if (state_reg == ST_SR_CHK)
        begin
            rd_data_reg <= prefix_mem[mid_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            pick_valid_reg <= 1'b0;
            pick_reg       <= '0;
            done_reg       <= 1'b0;
            done_data_reg  <= '0;
            operand_reg    <= '0;
            lo_prod_reg    <= '0;
            thr_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            mid_reg        <= '0;
        end
        else
        begin
            // output register
            if (done_reg && out_free)
            begin
                pick_reg       <= done_data_reg;
                pick_valid_reg <= 1'b1;
                done_reg       <= 1'b0;
            end
            else if (pick_take)
            begin
                pick_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (job_take)
                    begin
                        if (job.cmd == CMD_LOAD)
                        begin
                            operand_reg <= job.fitness;
                            if (job.first)
                            begin
                                count_reg <= '0;
                                total_reg <= '0;
                            end
                            state_reg <= ST_LD_MUL;
                        end
                        else if (count_reg == '0)
                        begin
                            done_data_reg.chosen_index <= '0;
                            done_data_reg.empty_error  <= 1'b1;
                            done_reg                   <= 1'b1;
                        end
                        else
                        begin
                            operand_reg <= job.random_fraction;
                            lo_reg      <= '0;
                            hi_reg      <= AW'(count_reg - CW'(1));
                            state_reg   <= ST_SL_MLO;
                        end
                    end
                end
                ST_LD_MUL: begin
                    state_reg <= ST_LD_ACC;
                end
                ST_LD_ACC: begin
                    if (mem_we)
                    begin
                        total_reg <= acc_next;
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_SL_MLO: begin
                    state_reg <= ST_SL_MHI;
                end
                ST_SL_MHI: begin
                    lo_prod_reg <= mul_p;
                    state_reg   <= ST_SL_THR;
                end
                ST_SL_THR: begin
                    thr_reg   <= thr_full[SUM_W+15:16];
                    state_reg <= ST_SR_CHK;
                end
                ST_SR_CHK: begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid_next;
                        state_reg <= ST_SR_CMP;
                    end
                    else
                    begin
                        done_data_reg.chosen_index <= idx_wide[IDX_W-1:0];
                        done_data_reg.empty_error  <= 1'b0;
                        done_reg                   <= 1'b1;
                        state_reg                  <= ST_IDLE;
                    end
                end
                ST_SR_CMP: begin
                    if (rd_data_reg > thr_reg)
                    begin
                        hi_reg <= mid_reg;
                    end
                    else
                    begin
                        lo_reg <= mid_reg + AW'(1);
                    end
                    state_reg <= ST_SR_CHK;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign pick_valid = pick_valid_reg;
    assign pick       = pick_reg;

endmodule
